// ===== rtl/core/sqct_pkg.sv =====
package sqct_pkg;

   // field widths of the sprite and corner words
   localparam int DIM_W   = 23;
   localparam int COORD_W = 24;
   localparam int SCALE_W = 16;
   localparam int ANGLE_W = 16;
   localparam int DEPTH_W = 16;

   // fixed point fraction bits of coordinates and scales
   localparam int FRAC_BITS = 8;
   // fraction bits of the sine and cosine values (q1.15)
   localparam int TRIG_FRAC = 15;
   // magnitude width of one sine table entry, 0 .. 32768
   localparam int TRIG_MAG_W = 16;

   // defaults for the top level parameters
   localparam int ANGLE_BITS_DEF      = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // quadrant of the binary angle
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic        [DIM_W-1:0]   width;
      logic        [DIM_W-1:0]   height;
      logic signed [COORD_W-1:0] pivot_x;
      logic signed [COORD_W-1:0] pivot_y;
      logic signed [SCALE_W-1:0] scale_x;
      logic signed [SCALE_W-1:0] scale_y;
      logic        [ANGLE_W-1:0] angle;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic        [DEPTH_W-1:0] depth;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] top_left_x;
      logic signed [COORD_W-1:0] top_left_y;
      logic signed [COORD_W-1:0] top_right_x;
      logic signed [COORD_W-1:0] top_right_y;
      logic signed [COORD_W-1:0] bottom_left_x;
      logic signed [COORD_W-1:0] bottom_left_y;
      logic signed [COORD_W-1:0] bottom_right_x;
      logic signed [COORD_W-1:0] bottom_right_y;
      logic        [DEPTH_W-1:0] corner_depth;
   } rsp_word_type;

endpackage

// ===== rtl/core/sprite_quad_corner_transform_unit.sv =====
// sprite quad corner transform
// takes one sprite word on req (size, pivot, per-axis scale, binary angle,
// position, depth) and returns one word on rsp with the four transformed
// corners of the sprite quad, saturated to the signed q15.8 range, and the
// depth copied through
// channels: valid/stall on both sides; a word moves at a clock edge with
// valid high and stall low
// throughput: one sprite word per clock, sustained, while rsp is not stalled
// stages: five register stages (table read, scale multiply, rotate multiply,
// sum and round, translate and saturate); rsp_data comes straight from the
// register of the last stage
// stall: each stage moves on when the stage after it is empty or moving, so
// bubbles close up behind a stalled rsp and req keeps being taken until all
// five stages are full; req_stall follows rsp_stall combinationally only then
// reset: synchronous, clears every stage valid bit; nothing is in flight after
// it and the sine table is a constant rom, so there is no warm-up time
module sprite_quad_corner_transform_unit #(
   parameter int ANGLE_BITS      = sqct_pkg::ANGLE_BITS_DEF,
   parameter int SINE_TABLE_BITS = sqct_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sqct_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sqct_pkg::rsp_word_type rsp_data
);
   import sqct_pkg::*;

   // widths of the datapath
   localparam int LX_W    = COORD_W + 1;              // corner minus pivot
   localparam int TRIG_W  = TRIG_MAG_W + 1;           // signed sine or cosine
   localparam int SX_W    = LX_W + SCALE_W;           // scaled offset
   localparam int PROD_W  = SX_W + TRIG_W;            // rotated term
   localparam int SUM_W   = PROD_W + 1;               // sum of two terms
   localparam int RSHIFT  = FRAC_BITS + TRIG_FRAC;    // rounding shift
   localparam int RND_W   = SUM_W - RSHIFT;           // rounded rotation
   localparam int SAT_W   = RND_W + 1;                // rotation plus position

   // sine rom geometry
   localparam int TAB_N    = 1 << SINE_TABLE_BITS;
   localparam int ADDR_W   = SINE_TABLE_BITS + 1;
   localparam int REM_W    = ANGLE_BITS - 2;
   localparam int WIDE_W   = REM_W + SINE_TABLE_BITS;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (RSHIFT - 1));

   typedef logic [TRIG_MAG_W-1:0] sine_rom_type [TAB_N+1];

   // quarter wave of sine in q1.15, entry i = sin(pi*i / 2^(bits+1)),
   // from an integer power series with q30 arguments
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  r;
      longint       sum;
      for (int i = 0; i <= TAB_N; i++) begin
         x = (64'd1686629713 * 64'(i) + 64'(TAB_N / 2)) >> SINE_TABLE_BITS;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (64'(sum) + 64'd16384) >> 15;
         if (r > 64'd32768) begin
            r = 64'd32768;
         end
         rom[i] = r[TRIG_MAG_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic signed [COORD_W-1:0] res;
      if (v > SAT_W'(COORD_MAX)) begin
         res = COORD_MAX;
      end else if (v < SAT_W'(COORD_MIN)) begin
         res = COORD_MIN;
      end else begin
         res = v[COORD_W-1:0];
      end
      return res;
   endfunction

   // stage valid bits and move enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   // a stage loads when it is empty or its contents move on
   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------- stage 1: rom read, corner offsets ----------------
   logic [ANGLE_BITS-1:0]       ang_in;
   logic [REM_W-1:0]            ang_rem_in;
   logic [WIDE_W-1:0]           ang_wide_in;
   logic [ADDR_W-1:0]           lo_addr_in;
   logic [ADDR_W-1:0]           hi_addr_in;
   quad_type                    quad_in;
   logic signed [LX_W-1:0]      lx_in [2];
   logic signed [LX_W-1:0]      ly_in [2];

   always_comb begin
      ang_in      = req_data.angle[ANGLE_W-1 -: ANGLE_BITS];
      quad_in     = quad_type'(ang_in[ANGLE_BITS-1 -: 2]);
      ang_rem_in  = ang_in[REM_W-1:0];
      // cut or zero-pad the remainder to the table index width
      ang_wide_in = {ang_rem_in, {SINE_TABLE_BITS{1'b0}}};
      lo_addr_in  = {1'b0, ang_wide_in[WIDE_W-1 -: SINE_TABLE_BITS]};
      hi_addr_in  = ADDR_W'(TAB_N) - lo_addr_in;
      // left / top edge at zero, right / bottom edge at width / height
      lx_in[0] = LX_W'(0) - LX_W'(req_data.pivot_x);
      lx_in[1] = $signed({2'b00, req_data.width}) - LX_W'(req_data.pivot_x);
      ly_in[0] = LX_W'(0) - LX_W'(req_data.pivot_y);
      ly_in[1] = $signed({2'b00, req_data.height}) - LX_W'(req_data.pivot_y);
   end

   logic [TRIG_MAG_W-1:0]       sin_lo_ff, sin_hi_ff;
   quad_type                    quad_ff;
   logic signed [LX_W-1:0]      lx_ff [2];
   logic signed [LX_W-1:0]      ly_ff [2];
   logic signed [SCALE_W-1:0]   scx1_ff, scy1_ff;
   logic signed [COORD_W-1:0]   posx1_ff, posy1_ff;
   logic [DEPTH_W-1:0]          depth1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         sin_lo_ff <= SINE_ROM[lo_addr_in];
         sin_hi_ff <= SINE_ROM[hi_addr_in];
         quad_ff   <= quad_in;
         lx_ff     <= lx_in;
         ly_ff     <= ly_in;
         scx1_ff   <= req_data.scale_x;
         scy1_ff   <= req_data.scale_y;
         posx1_ff  <= req_data.pos_x;
         posy1_ff  <= req_data.pos_y;
         depth1_ff <= req_data.depth;
      end
   end

   // ---------------- stage 2: scale, quadrant fold ----------------
   logic signed [TRIG_W-1:0]    lo_s, hi_s;
   logic signed [TRIG_W-1:0]    sn_in, cs_in;
   logic signed [SX_W-1:0]      sx_in [2];
   logic signed [SX_W-1:0]      sy_in [2];

   always_comb begin
      lo_s = $signed({1'b0, sin_lo_ff});
      hi_s = $signed({1'b0, sin_hi_ff});
      case (quad_ff)
         QUAD_0: begin
            sn_in = lo_s;
            cs_in = hi_s;
         end
         QUAD_1: begin
            sn_in = hi_s;
            cs_in = -lo_s;
         end
         QUAD_2: begin
            sn_in = -lo_s;
            cs_in = -hi_s;
         end
         QUAD_3: begin
            sn_in = -hi_s;
            cs_in = lo_s;
         end
         default: begin
            sn_in = lo_s;
            cs_in = hi_s;
         end
      endcase
      for (int i = 0; i < 2; i++) begin
         sx_in[i] = SX_W'(lx_ff[i]) * SX_W'(scx1_ff);
         sy_in[i] = SX_W'(ly_ff[i]) * SX_W'(scy1_ff);
      end
   end

   logic signed [TRIG_W-1:0]    sn_ff, cs_ff;
   logic signed [SX_W-1:0]      sx_ff [2];
   logic signed [SX_W-1:0]      sy_ff [2];
   logic signed [COORD_W-1:0]   posx2_ff, posy2_ff;
   logic [DEPTH_W-1:0]          depth2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         sn_ff     <= sn_in;
         cs_ff     <= cs_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         posx2_ff  <= posx1_ff;
         posy2_ff  <= posy1_ff;
         depth2_ff <= depth1_ff;
      end
   end

   // ---------------- stage 3: rotation products ----------------
   logic signed [PROD_W-1:0]    xc_in [2];
   logic signed [PROD_W-1:0]    xs_in [2];
   logic signed [PROD_W-1:0]    yc_in [2];
   logic signed [PROD_W-1:0]    ys_in [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         xc_in[i] = PROD_W'(sx_ff[i]) * PROD_W'(cs_ff);
         xs_in[i] = PROD_W'(sx_ff[i]) * PROD_W'(sn_ff);
         yc_in[i] = PROD_W'(sy_ff[i]) * PROD_W'(cs_ff);
         ys_in[i] = PROD_W'(sy_ff[i]) * PROD_W'(sn_ff);
      end
   end

   logic signed [PROD_W-1:0]    xc_ff [2];
   logic signed [PROD_W-1:0]    xs_ff [2];
   logic signed [PROD_W-1:0]    yc_ff [2];
   logic signed [PROD_W-1:0]    ys_ff [2];
   logic signed [COORD_W-1:0]   posx3_ff, posy3_ff;
   logic [DEPTH_W-1:0]          depth3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         xc_ff     <= xc_in;
         xs_ff     <= xs_in;
         yc_ff     <= yc_in;
         ys_ff     <= ys_in;
         posx3_ff  <= posx2_ff;
         posy3_ff  <= posy2_ff;
         depth3_ff <= depth2_ff;
      end
   end

   // ---------------- stage 4: sum and round ----------------
   // corner k: x offset from bit 0 (left/right), y offset from bit 1 (top/bottom)
   logic signed [SUM_W-1:0]     sum_x [4];
   logic signed [SUM_W-1:0]     sum_y [4];
   logic signed [RND_W-1:0]     rx_in [4];
   logic signed [RND_W-1:0]     ry_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum_x[k] = SUM_W'(xc_ff[k % 2]) - SUM_W'(ys_ff[k / 2]) + ROUND_HALF;
         sum_y[k] = SUM_W'(xs_ff[k % 2]) + SUM_W'(yc_ff[k / 2]) + ROUND_HALF;
         // floor after adding half: a half goes toward plus infinity
         rx_in[k] = $signed(sum_x[k][SUM_W-1:RSHIFT]);
         ry_in[k] = $signed(sum_y[k][SUM_W-1:RSHIFT]);
      end
   end

   logic signed [RND_W-1:0]     rx_ff [4];
   logic signed [RND_W-1:0]     ry_ff [4];
   logic signed [COORD_W-1:0]   posx4_ff, posy4_ff;
   logic [DEPTH_W-1:0]          depth4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         rx_ff     <= rx_in;
         ry_ff     <= ry_in;
         posx4_ff  <= posx3_ff;
         posy4_ff  <= posy3_ff;
         depth4_ff <= depth3_ff;
      end
   end

   // ---------------- stage 5: translate and saturate ----------------
   logic signed [COORD_W-1:0]   cx_in [4];
   logic signed [COORD_W-1:0]   cy_in [4];
   rsp_word_type                rsp_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cx_in[k] = sat_coord(SAT_W'(rx_ff[k]) + SAT_W'(posx4_ff));
         cy_in[k] = sat_coord(SAT_W'(ry_ff[k]) + SAT_W'(posy4_ff));
      end
      rsp_in.top_left_x     = cx_in[0];
      rsp_in.top_left_y     = cy_in[0];
      rsp_in.top_right_x    = cx_in[1];
      rsp_in.top_right_y    = cy_in[1];
      rsp_in.bottom_left_x  = cx_in[2];
      rsp_in.bottom_left_y  = cy_in[2];
      rsp_in.bottom_right_x = cx_in[3];
      rsp_in.bottom_right_y = cy_in[3];
      rsp_in.corner_depth   = depth4_ff;
   end

   rsp_word_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks ----------------
   // req is held back only when every stage is full and rsp is stalled
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall))
      else $error("req stalled with a free pipeline stage");

   // an accepted word always lands in the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word not captured");

   // a taken result with nothing behind it leaves the output empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v4_ff) |=> !rsp_valid)
      else $error("result word repeated");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
   import sqct_pkg::*;

   // predictor setup, mirrors the default build of the unit
   localparam int ANG_BITS    = ANGLE_BITS_DEF;
   localparam int TAB_BITS    = SINE_TABLE_BITS_DEF;
   localparam int TAB_N       = 1 << TAB_BITS;
   localparam int ROUND_SHIFT = FRAC_BITS + TRIG_FRAC;
   // pi/2 in q2.30, seed of the sine power series
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // run control
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 12;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // quarter-wave sine rom, q1.15 magnitudes
   int unsigned  sine_q15 [0:TAB_N];
   // corner words still owed by the unit, oldest first
   rsp_word_type corners_due [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int idle_cycles   = 0;

   sprite_quad_corner_transform_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // sin(pi*i/2^(TAB_BITS+1)) by an integer taylor series in q2.30,
   // then rounded to nearest q1.15
   function automatic void build_sine_rom();
      longint unsigned x, term, mag;
      longint          sum;
      int              i, k;
      for (i = 0; i <= TAB_N; i++) begin
         x    = (HALF_PI_Q30 * longint'(i) + longint'(TAB_N >> 1)) / longint'(TAB_N);
         term = x;
         sum  = longint'(x);
         for (k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k & 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         mag = (longint'(sum) + (64'd1 << 14)) >> 15;
         if (mag > 32768) mag = 32768;
         sine_q15[i] = int'(mag);
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   // four corners of one sprite: pivot shift, per-axis scale, rotate, translate
   function automatic rsp_word_type transform_sprite(input req_word_type s);
      rsp_word_type               c;
      logic signed [COORD_W-1:0]  xs [4];
      logic signed [COORD_W-1:0]  ys [4];
      int unsigned                a, r, idx;
      logic [1:0]                 q;
      longint                     lo, hi, sn, cs;
      longint                     w, h, px, py, scx, scy, tx, ty;
      longint                     cx, cy, sx, sy, rx, ry;
      int                         k;
      // top ANG_BITS of the angle; quadrant, then the truncated table index
      a = int'(s.angle) >> (ANGLE_W - ANG_BITS);
      q = 2'(a >> (ANG_BITS - 2));
      r = a & ((1 << (ANG_BITS - 2)) - 1);
      if (ANG_BITS - 2 >= TAB_BITS) idx = r >> (ANG_BITS - 2 - TAB_BITS);
      else idx = r << (TAB_BITS - (ANG_BITS - 2));
      idx = idx & (TAB_N - 1);
      lo = longint'(sine_q15[idx]);
      hi = longint'(sine_q15[TAB_N - idx]);
      case (quad_type'(q))
         QUAD_0: begin sn = lo;  cs = hi;  end
         QUAD_1: begin sn = hi;  cs = -lo; end
         QUAD_2: begin sn = -lo; cs = -hi; end
         default: begin sn = -hi; cs = lo; end
      endcase
      w   = longint'(s.width);
      h   = longint'(s.height);
      px  = longint'(s.pivot_x);
      py  = longint'(s.pivot_y);
      scx = longint'(s.scale_x);
      scy = longint'(s.scale_y);
      tx  = longint'(s.pos_x);
      ty  = longint'(s.pos_y);
      // corner order: (0,0) (w,0) (0,h) (w,h)
      for (k = 0; k < 4; k++) begin
         cx = (k & 1) ? w : longint'(0);
         cy = (k & 2) ? h : longint'(0);
         sx = (cx - px) * scx;
         sy = (cy - py) * scy;
         // floor after adding half: a half goes up
         rx = (sx * cs - sy * sn + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         ry = (sx * sn + sy * cs + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         xs[k] = clamp_coord(tx + rx);
         ys[k] = clamp_coord(ty + ry);
      end
      c.top_left_x     = xs[0];
      c.top_left_y     = ys[0];
      c.top_right_x    = xs[1];
      c.top_right_y    = ys[1];
      c.bottom_left_x  = xs[2];
      c.bottom_left_y  = ys[2];
      c.bottom_right_x = xs[3];
      c.bottom_right_y = ys[3];
      c.corner_depth   = s.depth;
      return c;
   endfunction

   // ---------------------------------------------------------------
   // sprite words
   // ---------------------------------------------------------------

   function automatic req_word_type make_sprite(input int w, input int h, input int px,
                                                input int py, input int scx, input int scy,
                                                input int ang, input int x, input int y,
                                                input int d);
      req_word_type s;
      s.width   = DIM_W'(w);
      s.height  = DIM_W'(h);
      s.pivot_x = COORD_W'(px);
      s.pivot_y = COORD_W'(py);
      s.scale_x = SCALE_W'(scx);
      s.scale_y = SCALE_W'(scy);
      s.angle   = ANGLE_W'(ang);
      s.pos_x   = COORD_W'(x);
      s.pos_y   = COORD_W'(y);
      s.depth   = DEPTH_W'(d);
      return s;
   endfunction

   // zero, the largest or the smallest value of a field, or the value as it is
   function automatic logic [COORD_W-1:0] extreme_of(input logic [COORD_W-1:0] v,
                                                     input int bits, input bit signed_field);
      logic [COORD_W-1:0] top;
      top = COORD_W'(1) << (bits - 1);
      case ($urandom_range(3))
         0: return '0;
         1: return signed_field ? top - 1'b1 : (top << 1) - 1'b1;
         2: return signed_field ? top : '0;
         default: return v;
      endcase
   endfunction

   function automatic req_word_type random_sprite();
      req_word_type        s;
      logic [7*32-1:0]     noise;
      int unsigned         kind;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      s     = noise[$bits(req_word_type)-1:0];
      kind  = $urandom_range(9);
      if (kind < 6 || kind == 9) begin
         // screen-sized sprites, scales within two, so most corners stay in range
         s.width   = DIM_W'($urandom_range(256 * 256));
         s.height  = DIM_W'($urandom_range(256 * 256));
         s.pivot_x = COORD_W'(int'($urandom_range(512 * 256)) - 128 * 256);
         s.pivot_y = COORD_W'(int'($urandom_range(512 * 256)) - 128 * 256);
         s.scale_x = SCALE_W'(int'($urandom_range(1024)) - 512);
         s.scale_y = SCALE_W'(int'($urandom_range(1024)) - 512);
         s.pos_x   = COORD_W'(int'($urandom_range(4096 * 256)) - 2048 * 256);
         s.pos_y   = COORD_W'(int'($urandom_range(4096 * 256)) - 2048 * 256);
         // just around a quadrant boundary
         if (kind == 9) s.angle = {s.angle[15:14], 14'd0} + 16'($urandom_range(2)) - 16'd1;
      end else if (kind == 8) begin
         s.width   = DIM_W'(extreme_of(COORD_W'(s.width), DIM_W, 1'b0));
         s.height  = DIM_W'(extreme_of(COORD_W'(s.height), DIM_W, 1'b0));
         s.pivot_x = extreme_of(s.pivot_x, COORD_W, 1'b1);
         s.pivot_y = extreme_of(s.pivot_y, COORD_W, 1'b1);
         s.scale_x = SCALE_W'(extreme_of(COORD_W'(s.scale_x), SCALE_W, 1'b1));
         s.scale_y = SCALE_W'(extreme_of(COORD_W'(s.scale_y), SCALE_W, 1'b1));
         s.angle   = ANGLE_W'(extreme_of(COORD_W'(s.angle), ANGLE_W, 1'b0));
         s.pos_x   = extreme_of(s.pos_x, COORD_W, 1'b1);
         s.pos_y   = extreme_of(s.pos_y, COORD_W, 1'b1);
         s.depth   = DEPTH_W'(extreme_of(COORD_W'(s.depth), DEPTH_W, 1'b0));
      end
      // otherwise every bit stays random, mostly saturating
      return s;
   endfunction

   // ---------------------------------------------------------------
   // req side
   // ---------------------------------------------------------------

   // valid stays high after a handshake so back-to-back words need no
   // second assignment in the same step; the next call decides
   task automatic send_sprite(input req_word_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      corners_due.push_back(transform_sprite(s));
   endtask

   // hold req off until every owed corner word has come back
   task automatic drain_corners();
      req_valid <= 1'b0;
      @(posedge clock);
      while (corners_due.size() != 0) @(posedge clock);
   endtask

   // random words with a full drain in the middle
   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n == count / 2) drain_corners();
         send_sprite(random_sprite());
      end
   endtask

   // ---------------------------------------------------------------
   // rsp side
   // ---------------------------------------------------------------

   // receiver backpressure, redrawn every clock
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // each accepted corner word against the oldest prediction
   always @(posedge clock) begin : check_corners
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (corners_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected corner word, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            want = corners_due.pop_front();
            compare_field("top_left_x", 32'(want.top_left_x), 32'(rsp_data.top_left_x));
            compare_field("top_left_y", 32'(want.top_left_y), 32'(rsp_data.top_left_y));
            compare_field("top_right_x", 32'(want.top_right_x),
                          32'(rsp_data.top_right_x));
            compare_field("top_right_y", 32'(want.top_right_y),
                          32'(rsp_data.top_right_y));
            compare_field("bottom_left_x", 32'(want.bottom_left_x),
                          32'(rsp_data.bottom_left_x));
            compare_field("bottom_left_y", 32'(want.bottom_left_y),
                          32'(rsp_data.bottom_left_y));
            compare_field("bottom_right_x", 32'(want.bottom_right_x),
                          32'(rsp_data.bottom_right_x));
            compare_field("bottom_right_y", 32'(want.bottom_right_y),
                          32'(rsp_data.bottom_right_y));
            compare_field("corner_depth", 32'(want.corner_depth),
                          32'(rsp_data.corner_depth));
         end
      end
   end

   // no word moving on either side for too long means a hang
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved in %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // all-zero, identity, centered pivot, every field at its top and bottom
   task automatic test_corner_cases();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_sprite(make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_sprite(make_sprite(16 << 8, 16 << 8, 0, 0, 256, 256, 0, 100 << 8, 50 << 8,
                              'h1234));
      send_sprite(make_sprite(32 << 8, 8 << 8, 16 << 8, 4 << 8, 256, 256, 'h1000,
                              -20 << 8, 30 << 8, 1));
      send_sprite(make_sprite('h7FFFFF, 'h7FFFFF, 'h7FFFFF, 'h7FFFFF, 'h7FFF, 'h7FFF,
                              'hFFFF, 'h7FFFFF, 'h7FFFFF, 'hFFFF));
      send_sprite(make_sprite(0, 0, 'h800000, 'h800000, 'h8000, 'h8000, 0,
                              'h800000, 'h800000, 0));
   endtask

   // each quadrant, the diagonal, and the angle bits below the table index
   task automatic test_quadrants();
      int unsigned turns [8] = '{'h4000, 'h8000, 'hC000, 'h2000, 'h000F, 'h0010,
                                 'h3FFF, 'hFFFF};
      send_idle_pct = 24;
      stall_pct     = 24;
      foreach (turns[i])
         send_sprite(make_sprite(24 << 8, 12 << 8, 12 << 8, 6 << 8, 256, 384, turns[i],
                                 10 << 8, -10 << 8, i));
   endtask

   // exact halves both sides of zero, and mirrored sprites
   task automatic test_rounding_and_mirror();
      send_sprite(make_sprite(2, 2, 1, 1, 128, 128, 0, 0, 0, 'h00AA));
      send_sprite(make_sprite(2, 2, 1, 1, -128, -128, 0, 5, -5, 'h0055));
      send_sprite(make_sprite(40 << 8, 20 << 8, 0, 0, -256, 256, 'h1555, 0, 0, 7));
      send_sprite(make_sprite(40 << 8, 20 << 8, 20 << 8, 10 << 8, -256, -256, 'h9000,
                              300 << 8, 200 << 8, 8));
      send_sprite(make_sprite(3 << 8, 5 << 8, 1 << 8, 2 << 8, 'h8000, 'h7FFF, 'h6000,
                              -400 << 8, 400 << 8, 9));
   endtask

   // corners pushed past both ends of the coordinate range
   task automatic test_saturation();
      send_sprite(make_sprite('h7FFFFF, 'h7FFFFF, 0, 0, 'h7FFF, 'h7FFF, 0,
                              'h7FFFFF, 'h7FFFFF, 'hBEEF));
      send_sprite(make_sprite('h7FFFFF, 'h7FFFFF, 0, 0, 'h7FFF, 'h7FFF, 'h8000,
                              'h800000, 'h800000, 'h0F0F));
      send_sprite(make_sprite('h400000, 'h100000, 'h200000, 'h080000, 'h0400, 'h0400,
                              'h4000, 0, 0, 'hF0F0));
   endtask

   // back to back, one word per clock
   task automatic test_streaming();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(480);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 84;
      stall_pct     = 0;
      run_random(470);
   endtask

   // pipeline fills and req_stall follows rsp_stall
   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      stall_pct     = 84;
      run_random(470);
   endtask

   task automatic test_mixed_idling();
      send_idle_pct = 24;
      stall_pct     = 24;
      run_random(470);
   endtask

   initial begin
      build_sine_rom();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_corner_cases();
      test_quadrants();
      test_rounding_and_mirror();
      test_saturation();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();

      // let the last words out, then watch for strays
      stall_pct = 0;
      drain_corners();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
